>>> hdl/dht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_pkg
// shared constants, codes and types of the double hashing table core
// ----------------------------------------------------------------------------
package dht_pkg;

  // default sizes
  localparam int TABLE_SIZE_DEF   = 11;
  localparam int STEP_MODULUS_DEF = 7;
  localparam int VALUE_BITS_DEF   = 16;

  // stream word widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 16;

  // field widths
  localparam int MODE_W   = 2;
  localparam int KEY_W    = 16;
  localparam int ITEM_W   = 16;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int PROBE_W  = 4;

  // latency of one constant modulo unit, and of the hashing chain
  localparam int MOD_LAT   = 3;
  localparam int HASH_LAST = 2 * MOD_LAT;
  localparam int HC_W      = 3;

  typedef logic [MODE_W-1:0]   mode_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_SEARCH = 2'd1;
  localparam mode_t MODE_DELETE = 2'd2;

  localparam status_t STAT_DONE      = 3'd0;
  localparam status_t STAT_NOT_FOUND = 3'd1;
  localparam status_t STAT_FULL      = 3'd2;
  localparam status_t STAT_EMPTY     = 3'd3;
  localparam status_t STAT_ZERO      = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_FIN
  } dht_state_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot_index;
    logic [PROBE_W-1:0]  probe_count;
  } dht_res_t;

endpackage
`default_nettype wire

>>> hdl/dht_modc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_modc
// pipelined remainder by a constant: reciprocal multiply, back multiply and
// one correcting subtract, three register stages
// ----------------------------------------------------------------------------
module dht_modc #(
  parameter int OP_W    = 16,
  parameter int DIVISOR = 11
) (
  input  wire logic                       clk,
  input  wire logic [OP_W-1:0]            op,
  output logic      [$clog2(DIVISOR)-1:0] rem
);

  localparam int RW = $clog2(DIVISOR);
  localparam int IW = (OP_W > RW + 1) ? OP_W : RW + 1;
  localparam int SH = IW + 8;
  localparam logic [SH-1:0] RECIP = SH'((64'd1 << SH) / DIVISOR);

  logic [IW-1:0]    op_d_r;
  logic [IW-1:0]    q_r;
  logic [RW:0]      r_r;
  logic [RW-1:0]    rem_r;
  logic [IW+SH-1:0] prod;
  logic [IW-1:0]    qd;
  logic [IW-1:0]    diff;

  // quotient estimate is exact or one low
  assign prod = (IW + SH)'(op) * (IW + SH)'(RECIP);
  assign qd   = IW'(q_r * IW'(DIVISOR));
  assign diff = op_d_r - qd;

  always_ff @(posedge clk) begin
    op_d_r <= IW'(op);
    q_r    <= prod[IW+SH-1:SH];
    r_r    <= diff[RW:0];
    rem_r  <= (r_r >= (RW + 1)'(DIVISOR)) ? RW'(r_r - (RW + 1)'(DIVISOR)) : RW'(r_r);
  end

  assign rem = rem_r;

endmodule
`default_nettype wire

>>> hdl/double_hash_table_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_hash_table_core
// open addressed value table with double hashing probe sequence
//
// channel | ports | word contents
// in      | in_*  | tuser: mode; tdata: key, item_value
// out     | out_* | tdata: status, slot_index, probe_count
//
// a request runs from accept to the next accept through the hashing chain of
// constant modulo units and then k probes, where k is the number of probes
// (1 to TABLE_SIZE), one probe per cycle through the single read port
// rejected requests skip the hashing chain and the probes
// the result register lets the next request run while a result waits
// reset clears the per slot valid bits at once, no sweep
// ----------------------------------------------------------------------------
module double_hash_table_core #(
  parameter int TABLE_SIZE   = dht_pkg::TABLE_SIZE_DEF,
  parameter int STEP_MODULUS = dht_pkg::STEP_MODULUS_DEF,
  parameter int VALUE_BITS   = dht_pkg::VALUE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [dht_pkg::IN_TDATA_W-1:0]   in_tdata,   // key, item_value
  input  wire logic [dht_pkg::IN_TUSER_W-1:0]   in_tuser,   // mode
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [dht_pkg::OUT_TDATA_W-1:0]  out_tdata   // status, slot_index, probe_count
);

  localparam int PW  = $clog2(TABLE_SIZE);
  localparam int CW  = $clog2(TABLE_SIZE + 1);
  localparam int SRW = $clog2(STEP_MODULUS);

  dht_pkg::dht_state_t state_r, state_nxt;

  dht_pkg::mode_t           mode_r, mode_nxt;
  logic [dht_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0]    val_r, val_nxt;
  logic [dht_pkg::HC_W-1:0] hc_r, hc_nxt;
  logic [PW-1:0]            pos_r, pos_nxt;
  logic [PW-1:0]            step_r, step_nxt;
  logic [CW-1:0]            k_r, k_nxt;
  logic [CW-1:0]            occ_r, occ_nxt;
  dht_pkg::dht_res_t        res_r, res_nxt;
  dht_pkg::dht_res_t        out_r, out_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;

  logic [VALUE_BITS-1:0] mem [TABLE_SIZE];
  logic [TABLE_SIZE-1:0] vld_r;
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;

  dht_pkg::mode_t        in_mode;
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_acc;
  logic                  early;
  dht_pkg::status_t      early_status;
  logic [PW-1:0]         home_rem;
  logic [SRW-1:0]        raw_rem;
  logic [SRW-1:0]        stp0;
  logic [PW-1:0]         step_rem;
  logic [PW:0]           pos_sum;
  logic [PW-1:0]         pos_adv;
  logic [PW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] entry;
  logic                  hit;
  logic                  last_probe;
  logic                  hash_done;
  logic                  out_free;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] wr_data;
  logic [CW-1:0]         k_inc;

  // hashing chain
  dht_modc #(.OP_W(dht_pkg::KEY_W), .DIVISOR(TABLE_SIZE)) u_home (
    .clk (clk),
    .op  (key_r),
    .rem (home_rem)
  );

  dht_modc #(.OP_W(dht_pkg::KEY_W), .DIVISOR(STEP_MODULUS)) u_raw (
    .clk (clk),
    .op  (key_r),
    .rem (raw_rem)
  );

  assign stp0 = (raw_rem == '0) ? SRW'(1) : raw_rem;

  dht_modc #(.OP_W(SRW), .DIVISOR(TABLE_SIZE)) u_step (
    .clk (clk),
    .op  (stp0),
    .rem (step_rem)
  );

  assign in_mode   = in_tuser[dht_pkg::MODE_W-1:0];
  assign in_val    = VALUE_BITS'(in_tdata[dht_pkg::KEY_W +: dht_pkg::ITEM_W]);
  assign in_tready = (state_r == dht_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    early        = 1'b1;
    early_status = dht_pkg::STAT_DONE;
    if (in_val == '0) begin
      early_status = dht_pkg::STAT_ZERO;
    end else if (in_mode != dht_pkg::MODE_INSERT && in_mode != dht_pkg::MODE_SEARCH &&
                 in_mode != dht_pkg::MODE_DELETE) begin
      early_status = dht_pkg::STAT_NOT_FOUND;
    end else if (in_mode == dht_pkg::MODE_INSERT && occ_r == CW'(TABLE_SIZE)) begin
      early_status = dht_pkg::STAT_FULL;
    end else if (in_mode == dht_pkg::MODE_DELETE && occ_r == '0) begin
      early_status = dht_pkg::STAT_EMPTY;
    end else begin
      early = 1'b0;
    end
  end

  // probe walk
  assign pos_sum    = (PW + 1)'(pos_r) + (PW + 1)'(step_r);
  assign pos_adv    = (pos_sum >= (PW + 1)'(TABLE_SIZE)) ?
                      PW'(pos_sum - (PW + 1)'(TABLE_SIZE)) : PW'(pos_sum);
  assign rd_addr    = (state_r == dht_pkg::ST_HASH) ? home_rem : pos_adv;
  assign entry      = rd_vld_r ? rd_data_r : '0;
  assign hit        = (mode_r == dht_pkg::MODE_INSERT) ? (entry == '0) : (entry == val_r);
  assign last_probe = (k_r == CW'(TABLE_SIZE - 1));
  assign hash_done  = (hc_r == dht_pkg::HC_W'(dht_pkg::HASH_LAST));
  assign out_free   = !out_tvalid_r || out_tready;
  assign k_inc      = k_r + CW'(1);
  assign wr_en      = (state_r == dht_pkg::ST_PROBE) && hit && (mode_r != dht_pkg::MODE_SEARCH);
  assign wr_data    = (mode_r == dht_pkg::MODE_INSERT) ? val_r : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dht_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = early ? dht_pkg::ST_FIN : dht_pkg::ST_HASH;
        end
      end
      dht_pkg::ST_HASH: begin
        if (hash_done) begin
          state_nxt = dht_pkg::ST_PROBE;
        end
      end
      dht_pkg::ST_PROBE: begin
        if (hit || last_probe) begin
          state_nxt = dht_pkg::ST_FIN;
        end
      end
      dht_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = dht_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dht_pkg::ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    mode_nxt       = mode_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    hc_nxt         = hc_r;
    pos_nxt        = pos_r;
    step_nxt       = step_r;
    k_nxt          = k_r;
    occ_nxt        = occ_r;
    res_nxt        = res_r;
    out_nxt        = out_r;
    out_tvalid_nxt = out_tvalid_r;
    if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
    case (state_r)
      dht_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode;
          key_nxt  = in_tdata[dht_pkg::KEY_W-1:0];
          val_nxt  = in_val;
          hc_nxt   = '0;
          k_nxt    = '0;
          res_nxt  = '{status: early_status, slot_index: '0, probe_count: '0};
        end
      end
      dht_pkg::ST_HASH: begin
        hc_nxt = hc_r + dht_pkg::HC_W'(1);
        if (hash_done) begin
          pos_nxt  = home_rem;
          step_nxt = step_rem;
        end
      end
      dht_pkg::ST_PROBE: begin
        if (hit) begin
          res_nxt = '{status: dht_pkg::STAT_DONE,
                      slot_index: dht_pkg::SLOT_W'(pos_r),
                      probe_count: dht_pkg::PROBE_W'(k_inc)};
          if (mode_r == dht_pkg::MODE_INSERT) begin
            occ_nxt = occ_r + CW'(1);
          end else if (mode_r == dht_pkg::MODE_DELETE) begin
            occ_nxt = occ_r - CW'(1);
          end
        end else if (last_probe) begin
          res_nxt = '{status: (mode_r == dht_pkg::MODE_INSERT) ? dht_pkg::STAT_FULL :
                              dht_pkg::STAT_NOT_FOUND,
                      slot_index: '0,
                      probe_count: dht_pkg::PROBE_W'(TABLE_SIZE)};
        end else begin
          k_nxt   = k_inc;
          pos_nxt = pos_adv;
        end
      end
      dht_pkg::ST_FIN: begin
        if (out_free) begin
          out_nxt        = res_r;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= dht_pkg::ST_IDLE;
      occ_r        <= '0;
      out_tvalid_r <= 1'b0;
      hc_r         <= '0;
      k_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      occ_r        <= occ_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      hc_r         <= hc_nxt;
      k_r          <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    pos_r  <= pos_nxt;
    step_r <= step_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // empty until written
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[pos_r] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = dht_pkg::OUT_TDATA_W'({out_r.probe_count, out_r.slot_index, out_r.status});

endmodule
`default_nettype wire

>>> hdl/dht_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dht_checker
// port level checks of the double hashing table core
// ----------------------------------------------------------------------------
module dht_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [dht_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  dht_pkg::status_t            status;
  logic [dht_pkg::SLOT_W-1:0]  slot_index;
  logic [dht_pkg::PROBE_W-1:0] probe_count;

  assign status      = out_tdata[2:0];
  assign slot_index  = out_tdata[6:3];
  assign probe_count = out_tdata[10:7];

  // one request in flight
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while another is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed");

  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status != dht_pkg::STAT_DONE |-> slot_index == '0)
    else $error("failed request reports a slot");

  a_done_probes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == dht_pkg::STAT_DONE |-> probe_count != '0)
    else $error("completed request reports no probe");

  a_zero_probes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && status == dht_pkg::STAT_ZERO |-> probe_count == '0)
    else $error("zero value rejection reports probes");

endmodule

bind double_hash_table_core dht_checker u_dht_checker (.*);
`default_nettype wire

>>> tb/sv/double_hash_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_core_tb
// drives insert, search, delete and unused mode requests into the double
// hashing table core through random gaps and stalls on both channels, and
// checks every result word against a typed expectation or a local table copy
// ----------------------------------------------------------------------------
module double_hash_table_core_tb;
  import dht_pkg::*;

  localparam int    SLOTS        = TABLE_SIZE_DEF;
  localparam int    STEP_MOD     = STEP_MODULUS_DEF;
  localparam int    RANDOM_ITEMS = 1100;
  localparam int    IDLE_LIMIT   = 2000;
  localparam int    DRAIN_CYCLES = 40;
  localparam mode_t MODE_UNUSED  = 2'd3;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] slot_index;
    logic [PROBE_W-1:0] probe_count;
  } result_t;

  typedef struct {
    mode_t       mode;
    logic [15:0] key;
    logic [15:0] value;
    bit          typed;
    result_t     res;
  } dir_row_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // key, item_value
  logic [IN_TUSER_W-1:0]  in_tuser;   // mode
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // status, slot_index, probe_count

  logic [ITEM_W-1:0] table_slots [SLOTS];
  int                fill_count;
  result_t           pending_results[$];
  dir_row_t          dir_rows[$];
  int                err_count;
  int                idle_cycles;
  bit                no_idle;

  double_hash_table_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // local copy of the table, one request applied per call
  task automatic apply_request(input mode_t m, input logic [15:0] key,
                               input logic [15:0] val, output result_t r);
    int  pos;
    int  step;
    bit  hit;
    r = '{STAT_NOT_FOUND, '0, '0};
    if (val == 0) begin
      r.status = STAT_ZERO;
      return;
    end
    if (m == MODE_UNUSED) return;
    if (m == MODE_INSERT && fill_count >= SLOTS) begin
      r.status = STAT_FULL;
      return;
    end
    if (m == MODE_DELETE && fill_count == 0) begin
      r.status = STAT_EMPTY;
      return;
    end
    pos  = key % SLOTS;
    step = key % STEP_MOD;
    if (step == 0) step = 1;
    step = step % SLOTS;
    for (int k = 0; k < SLOTS; k++) begin
      hit = (m == MODE_INSERT) ? (table_slots[pos] == 0) : (table_slots[pos] == val);
      if (hit) begin
        if (m == MODE_INSERT) begin
          table_slots[pos] = val;
          fill_count++;
        end else if (m == MODE_DELETE) begin
          table_slots[pos] = '0;
          fill_count--;
        end
        r = '{STAT_DONE, pos[SLOT_W-1:0], 4'(k + 1)};
        return;
      end
      pos += step;
      if (pos >= SLOTS) pos -= SLOTS;
    end
    r = '{(m == MODE_INSERT) ? STAT_FULL : STAT_NOT_FOUND, '0, 4'(SLOTS)};
  endtask

  task automatic send_request(input mode_t m, input logic [15:0] key,
                              input logic [15:0] val, input bit typed,
                              input result_t typed_res);
    int      gap;
    result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tuser  = m;
    in_tdata  = {val, key};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    apply_request(m, key, val, r);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic add_row(input mode_t m, input logic [15:0] key, input logic [15:0] val,
                         input bit typed, input status_t st = STAT_DONE,
                         input int slot = 0, input int probes = 0);
    dir_row_t row;
    row.mode  = m;
    row.key   = key;
    row.value = val;
    row.typed = typed;
    row.res   = '{st, 4'(slot), 4'(probes)};
    dir_rows.push_back(row);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word %h", out_tdata);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_tdata[2:0] !== exp_r.status) begin
          $error("status expected %0d got %0d", exp_r.status, out_tdata[2:0]);
          err_count++;
        end
        if (out_tdata[6:3] !== exp_r.slot_index) begin
          $error("slot_index expected %0d got %0d", exp_r.slot_index, out_tdata[6:3]);
          err_count++;
        end
        if (out_tdata[10:7] !== exp_r.probe_count) begin
          $error("probe_count expected %0d got %0d", exp_r.probe_count, out_tdata[10:7]);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    int          r;
    mode_t       m;
    logic [15:0] key;
    logic [15:0] val;
    result_t     none;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    err_count   = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    fill_count  = 0;
    none        = '{STAT_DONE, '0, '0};
    foreach (table_slots[i]) table_slots[i] = '0;

    add_row(MODE_DELETE, 16'd5,     16'd1,     1, STAT_EMPTY, 0, 0);
    add_row(MODE_SEARCH, 16'd0,     16'd1,     1, STAT_NOT_FOUND, 0, SLOTS);
    add_row(MODE_INSERT, 16'd0,     16'd0,     1, STAT_ZERO, 0, 0);
    add_row(MODE_UNUSED, 16'd0,     16'd1,     1, STAT_NOT_FOUND, 0, 0);
    add_row(MODE_INSERT, 16'd0,     16'd1,     1, STAT_DONE, 0, 1);
    add_row(MODE_INSERT, 16'hffff,  16'hffff,  1, STAT_DONE, 8, 1);
    // duplicate value
    add_row(MODE_INSERT, 16'd0,     16'd1,     0);
    add_row(MODE_INSERT, 16'd11,    16'h8000,  0);
    add_row(MODE_SEARCH, 16'd0,     16'd1,     0);
    add_row(MODE_SEARCH, 16'hffff,  16'hffff,  0);
    add_row(MODE_UNUSED, 16'hffff,  16'hffff,  1, STAT_NOT_FOUND, 0, 0);
    add_row(MODE_INSERT, 16'd100,   16'h5555,  0);
    add_row(MODE_INSERT, 16'd200,   16'haaaa,  0);
    add_row(MODE_INSERT, 16'd300,   16'd3,     0);
    add_row(MODE_INSERT, 16'd400,   16'd4,     0);
    add_row(MODE_INSERT, 16'd500,   16'd5,     0);
    add_row(MODE_INSERT, 16'd600,   16'd6,     0);
    add_row(MODE_INSERT, 16'd700,   16'd7,     0);
    // table full now
    add_row(MODE_INSERT, 16'd3,     16'd9,     1, STAT_FULL, 0, 0);
    add_row(MODE_SEARCH, 16'd1234,  16'h1234,  1, STAT_NOT_FOUND, 0, SLOTS);
    add_row(MODE_DELETE, 16'd0,     16'd1,     0);
    add_row(MODE_DELETE, 16'd0,     16'd1,     0);
    add_row(MODE_DELETE, 16'd7,     16'hffff,  0);
    add_row(MODE_INSERT, 16'hffff,  16'd0,     1, STAT_ZERO, 0, 0);
    add_row(MODE_DELETE, 16'd0,     16'd0,     1, STAT_ZERO, 0, 0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i])
      send_request(dir_rows[i].mode, dir_rows[i].key, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i / 100) % 4 == 3);
      r = $urandom_range(0, 99);
      if (r < 40)      m = MODE_INSERT;
      else if (r < 70) m = MODE_SEARCH;
      else if (r < 95) m = MODE_DELETE;
      else             m = MODE_UNUSED;
      key = 16'($urandom);
      // small value pool so that searches and deletes hit
      r = $urandom_range(0, 99);
      if (r < 80)      val = 16'($urandom_range(1, 15));
      else if (r < 90) val = 16'($urandom);
      else if (r < 95) val = 16'd0;
      else             val = $urandom_range(0, 1) ? 16'hffff : 16'h8000;
      send_request(m, key, val, 0, none);
    end
    in_tvalid = 1'b0;
    no_idle   = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
